### rtl/core/hdr_tone_map_operator_defines.svh
// Assertion macros used by the tone map operator RTL
`ifndef HDR_TONE_MAP_OPERATOR_DEFINES_SVH
`define HDR_TONE_MAP_OPERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define TMO_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tone map assertion failed");
// condition must never be seen outside reset
`define TMO_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tone map forbidden condition seen");
`else
`define TMO_ASSERT(lbl, clk, rst, prop)
`define TMO_NEVER(lbl, clk, rst, cond)
`endif

`endif

### rtl/core/tmo_pkg.sv
package tmo_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 24;

   localparam int DATA_W   = 32;
   localparam int DIV_W    = 40;  // divisor width, covers Reinhard and normalise
   localparam int ANGLE_W  = 34;  // binary angle with headroom
   localparam int CORDIC_W = 52;  // 33-bit input scaled by 2^16 plus growth

   localparam logic [15:0] REINHARD_K   = 16'd20972;  // 0.32 as 0.16
   localparam logic [33:0] QUARTER_TURN = 34'h040000000;

   // input commands
   localparam logic [1:0] CMD_SCAN  = 2'd0;
   localparam logic [1:0] CMD_MAP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // operator modes
   localparam logic [2:0] MODE_NONE      = 3'd0;
   localparam logic [2:0] MODE_REINHARD  = 3'd1;
   localparam logic [2:0] MODE_NORMALIZE = 3'd2;
   localparam logic [2:0] MODE_CLAMP     = 3'd3;
   localparam logic [2:0] MODE_ABS       = 3'd4;
   localparam logic [2:0] MODE_POSITIVE  = 3'd5;
   localparam logic [2:0] MODE_NEGATIVE  = 3'd6;
   localparam logic [2:0] MODE_SPHERICAL = 3'd7;

   // register indexes
   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_WRED    = 3'd1;
   localparam logic [2:0] REG_WGREEN  = 3'd2;
   localparam logic [2:0] REG_WBLUE   = 3'd3;
   localparam logic [2:0] REG_EPSILON = 3'd4;

   // reset values
   localparam logic [2:0]  MODE_RST    = MODE_REINHARD;
   localparam logic [15:0] WRED_RST    = 16'd13933;
   localparam logic [15:0] WGREEN_RST  = 16'd46871;
   localparam logic [15:0] WBLUE_RST   = 16'd4732;
   localparam logic [15:0] EPSILON_RST = 16'd1;

   // arctangent of 2^-i, 2^31 = pi
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

endpackage

### rtl/core/hdr_tone_map_operator.sv
// HDR tone map operator.
// req_ carries one pixel per transaction: req_tuser is the command (scan, map,
// clear peak), req_tdata the red, green and blue channels, signed fixed point.
// A scan folds r*r+g*g+b*b into the peak register, a clear zeroes it; neither
// produces a result. A map produces one rsp_ transaction with the mapped pixel.
// csr_ writes the operator mode, the three luma weights and the peak epsilon;
// write only while no transaction is in flight.
// One pixel is worked on at a time; req_tready is high in the idle state.
// Work per pixel: a clear acts at once; the simple modes (none, clamp, abs,
// positive, negative) go straight to the output; a scan squares and sums the
// three channels; Reinhard forms the luma, then runs three passes of the
// bit-serial divider; normalise takes a square root, then the divider, or only
// the root for a small peak; spherical runs two CORDIC passes and one square
// root, or one CORDIC pass when the arcsine argument is at or beyond one.
// A finished result sits in the rsp_ output register, so the next pixel is
// taken while it waits; a stalled receiver holds the block only once another
// result is ready to be stored. Reset clears the peak, restores the register
// defaults and drops any pending result. No memory, no clearing pass.
`include "hdr_tone_map_operator_defines.svh"

module hdr_tone_map_operator #(
   parameter int FRAC_BITS    = tmo_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = tmo_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // red_in [31:0], green_in [63:32], blue_in [95:64]
   input  logic [1:0]  req_tuser,   // cmd [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // red_out [31:0], green_out [63:32], blue_out [95:64]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int AW = tmo_pkg::ANGLE_W;
   localparam int DW = tmo_pkg::DIV_W;
   localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
   localparam logic [32:0]   ONE  = 33'(1) << FRAC_BITS;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_MUL   = 12'b0000_0000_0010,
      S_ACC   = 12'b0000_0000_0100,
      S_PEAK  = 12'b0000_0000_1000,
      S_KMUL  = 12'b0000_0001_0000,
      S_KADD  = 12'b0000_0010_0000,
      S_NSQ   = 12'b0000_0100_0000,
      S_DIV   = 12'b0000_1000_0000,
      S_SPH_R = 12'b0001_0000_0000,
      S_VSQ   = 12'b0010_0000_0000,
      S_SPH_G = 12'b0100_0000_0000,
      S_OUT   = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      JOB_SCAN = 2'd0,
      JOB_LUMA = 2'd1,
      JOB_VV   = 2'd2
   } job_type;

   typedef struct packed {
      logic div_start;
      logic sq_start;
      logic cor_start;
   } unit_start_type;

   state_type      state_ff, state_in;
   job_type        job_ff, job_in;
   unit_start_type start_ff, start_in;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] wr_ff, wr_in, wg_ff, wg_in, wb_ff, wb_in, eps_ff, eps_in;
   logic [63:0] peak_ff, peak_in;
   logic [31:0] r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [68:0] prod_ff, prod_in;
   logic [DW-1:0] div_ff, div_in;
   logic [31:0] ro_ff, ro_in, go_ff, go_in, bo_ff, bo_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;

   logic        req_acc, rsp_free;
   logic [31:0] chan, div_q, sq_root;
   logic        div_done, sq_done, cor_done;
   logic [63:0] sq_rad;
   logic [32:0] cor_x, cor_y, v;
   logic [AW-1:0] cor_z;
   logic signed [35:0] ma;
   logic signed [32:0] mb;
   logic [31:0] s_r, s_g, s_b;
   logic        v_hi, v_lo;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // channel chosen by the pass counter
   always_comb begin
      unique case (cnt_ff)
         2'd0:    chan = r_ff;
         2'd1:    chan = g_ff;
         default: chan = b_ff;
      endcase
   end

   // v = -green, and its range for the arcsine
   assign v    = 33'd0 - {g_ff[31], g_ff};
   assign v_hi = ($signed(v) >= $signed(ONE));
   assign v_lo = ($signed(v) <= -$signed(ONE));

   // shared multiplier operands
   always_comb begin
      ma = $signed({{4{chan[31]}}, chan});
      mb = $signed({chan[31], chan});
      if (state_ff == S_KMUL) begin
         ma = acc_ff[51:16];
         mb = $signed(33'(tmo_pkg::REINHARD_K));
      end else begin
         unique case (job_ff)
            JOB_LUMA: begin
               unique case (cnt_ff)
                  2'd0:    ma = $signed({20'b0, wr_ff});
                  2'd1:    ma = $signed({20'b0, wg_ff});
                  default: ma = $signed({20'b0, wb_ff});
               endcase
            end
            JOB_VV: begin
               ma = $signed({{3{v[32]}}, v});
               mb = $signed(v);
            end
            default: ;
         endcase
      end
   end

   // simple operators on one channel
   function automatic logic [31:0] sat_neg(input logic [31:0] c);
      return (c == 32'h8000_0000) ? 32'h7FFF_FFFF : (~c + 32'd1);
   endfunction

   function automatic logic [31:0] simple_op(input logic [2:0] m, input logic [31:0] c);
      logic [31:0] res;
      res = c;
      unique case (m)
         tmo_pkg::MODE_CLAMP, tmo_pkg::MODE_ABS: res = c[31] ? sat_neg(c) : c;
         tmo_pkg::MODE_POSITIVE: res = c[31] ? 32'h0 : c;
         tmo_pkg::MODE_NEGATIVE: res = c[31] ? sat_neg(c) : 32'h0;
         default: res = c;
      endcase
      return res;
   endfunction

   assign s_r = simple_op(mode_ff, r_ff);
   assign s_g = simple_op(mode_ff, g_ff);
   assign s_b = simple_op(mode_ff, b_ff);

   function automatic logic [31:0] red_of(input logic [AW-1:0] z);
      logic [AW-1:0] sum;
      sum = HALF + AW'($signed(z) >>> (32 - FRAC_BITS));
      return sum[31:0];
   endfunction

   function automatic logic [31:0] green_of(input logic [AW-1:0] z);
      logic [AW-1:0] dif;
      dif = HALF - AW'($signed(z) >>> (31 - FRAC_BITS));
      return dif[31:0];
   endfunction

   // unit operands
   assign sq_rad = (state_ff == S_NSQ) ? peak_ff
                 : 64'((66'(1) << (2 * FRAC_BITS)) - acc_ff);
   assign cor_x  = (state_ff == S_SPH_G) ? {1'b0, sq_root} : {r_ff[31], r_ff};
   assign cor_y  = (state_ff == S_SPH_G) ? v : {b_ff[31], b_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      start_in     = '0;
      mode_in      = mode_ff;
      wr_in        = wr_ff;
      wg_in        = wg_ff;
      wb_in        = wb_ff;
      eps_in       = eps_ff;
      peak_in      = peak_ff;
      r_in         = r_ff;
      g_in         = g_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      div_in       = div_ff;
      ro_in        = ro_ff;
      go_in        = go_ff;
      bo_in        = bo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tmo_pkg::REG_MODE:    mode_in = csr_data[2:0];
            tmo_pkg::REG_WRED:    wr_in   = csr_data;
            tmo_pkg::REG_WGREEN:  wg_in   = csr_data;
            tmo_pkg::REG_WBLUE:   wb_in   = csr_data;
            tmo_pkg::REG_EPSILON: eps_in  = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               r_in   = req_tdata[31:0];
               g_in   = req_tdata[63:32];
               b_in   = req_tdata[95:64];
               cnt_in = 2'd0;
               acc_in = '0;
               priority if (req_tuser == tmo_pkg::CMD_SCAN) begin
                  job_in   = JOB_SCAN;
                  state_in = S_MUL;
               end else if (req_tuser == tmo_pkg::CMD_CLEAR) begin
                  peak_in = '0;
               end else if (req_tuser == tmo_pkg::CMD_MAP) begin
                  priority if (mode_ff == tmo_pkg::MODE_REINHARD) begin
                     job_in   = JOB_LUMA;
                     state_in = S_MUL;
                  end else if (mode_ff == tmo_pkg::MODE_NORMALIZE) begin
                     start_in.sq_start = 1'b1;
                     state_in = S_NSQ;
                  end else if (mode_ff == tmo_pkg::MODE_SPHERICAL) begin
                     start_in.cor_start = 1'b1;
                     state_in = S_SPH_R;
                  end else begin
                     state_in = S_OUT;
                  end
               end else begin
                  // unused command: dropped, nothing changes
                  state_in = S_IDLE;
               end
            end
         end
         S_MUL: begin
            prod_in  = ma * mb;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + prod_ff[65:0];
            priority if (job_ff == JOB_VV) begin
               start_in.sq_start = 1'b1;
               state_in = S_VSQ;
            end else if (cnt_ff == 2'd2) begin
               state_in = (job_ff == JOB_SCAN) ? S_PEAK : S_KMUL;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_PEAK: begin
            if (acc_ff[63:0] > peak_ff) peak_in = acc_ff[63:0];
            state_in = S_IDLE;
         end
         S_KMUL: begin
            prod_in  = ma * mb;
            state_in = S_KADD;
         end
         S_KADD: begin
            // d = 2^F + floor(luma * 0.32)
            div_in = (DW'(1) << FRAC_BITS) + prod_ff[DW+15:16];
            cnt_in = 2'd0;
            start_in.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_NSQ: begin
            if (sq_done) begin
               if (sq_root > 32'(eps_ff)) begin
                  div_in = DW'(sq_root);
                  cnt_in = 2'd0;
                  start_in.div_start = 1'b1;
                  state_in = S_DIV;
               end else begin
                  ro_in    = r_ff;
                  go_in    = g_ff;
                  bo_in    = b_ff;
                  state_in = S_OUT;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               unique case (cnt_ff)
                  2'd0:    ro_in = div_q;
                  2'd1:    go_in = div_q;
                  default: bo_in = div_q;
               endcase
               if (cnt_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  cnt_in = cnt_ff + 2'd1;
                  start_in.div_start = 1'b1;
               end
            end
         end
         S_SPH_R: begin
            if (cor_done) begin
               ro_in = red_of(cor_z);
               bo_in = '0;
               priority if (v_hi) begin
                  go_in    = green_of(tmo_pkg::QUARTER_TURN);
                  state_in = S_OUT;
               end else if (v_lo) begin
                  go_in    = green_of(AW'(0) - tmo_pkg::QUARTER_TURN);
                  state_in = S_OUT;
               end else begin
                  job_in   = JOB_VV;
                  acc_in   = '0;
                  state_in = S_MUL;
               end
            end
         end
         S_VSQ: begin
            if (sq_done) begin
               start_in.cor_start = 1'b1;
               state_in = S_SPH_G;
            end
         end
         S_SPH_G: begin
            if (cor_done) begin
               go_in    = green_of(cor_z);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               priority if (mode_ff == tmo_pkg::MODE_REINHARD ||
                            mode_ff == tmo_pkg::MODE_NORMALIZE ||
                            mode_ff == tmo_pkg::MODE_SPHERICAL) begin
                  rsp_data_in = {bo_ff, go_ff, ro_ff};
               end else begin
                  rsp_data_in = {s_b, s_g, s_r};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= JOB_SCAN;
         start_ff     <= '0;
         mode_ff      <= tmo_pkg::MODE_RST;
         wr_ff        <= tmo_pkg::WRED_RST;
         wg_ff        <= tmo_pkg::WGREEN_RST;
         wb_ff        <= tmo_pkg::WBLUE_RST;
         eps_ff       <= tmo_pkg::EPSILON_RST;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         start_ff     <= start_in;
         mode_ff      <= mode_in;
         wr_ff        <= wr_in;
         wg_ff        <= wg_in;
         wb_ff        <= wb_in;
         eps_ff       <= eps_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff        <= r_in;
      g_ff        <= g_in;
      b_ff        <= b_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      div_ff      <= div_in;
      ro_ff       <= ro_in;
      go_ff       <= go_in;
      bo_ff       <= bo_in;
      rsp_data_ff <= rsp_data_in;
   end

   // the divider takes the channel selected by the pass counter
   tmo_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff.div_start),
      .dividend (chan),
      .divisor  (div_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   tmo_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff.sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   tmo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (start_ff.cor_start),
      .x_in  (cor_x),
      .y_in  (cor_y),
      .done  (cor_done),
      .angle (cor_z)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a clear transaction zeroes the peak in the next cycle
   `TMO_ASSERT(a_clear_peak, clock, reset,
      (req_acc && req_tuser == tmo_pkg::CMD_CLEAR) |=> (peak_ff == 64'd0))
   // the peak only grows while a scan completes
   `TMO_ASSERT(a_peak_grows, clock, reset,
      (state_ff == S_PEAK) |=> (peak_ff >= $past(peak_ff)))
   // a new result is only loaded from the output state
   `TMO_ASSERT(a_rsp_from_out, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
   // no unit is started while the block is idle
   `TMO_NEVER(a_no_start_idle, clock, reset,
      (state_ff == S_IDLE) && (start_ff != '0))

endmodule

### rtl/core/tmo_divider.sv
// Restoring divider, one quotient bit per cycle: sat32(trunc(c * 2^F / d))
module tmo_divider #(
   parameter int FRAC_BITS = tmo_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tmo_pkg::DATA_W-1:0]    dividend,
   input  logic [tmo_pkg::DIV_W-1:0]     divisor,
   output logic                          done,
   output logic [tmo_pkg::DATA_W-1:0]    quotient
);
   localparam int NW = tmo_pkg::DATA_W + FRAC_BITS;
   localparam int DW = tmo_pkg::DIV_W;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic          neg_ff, neg_in, zero_ff, zero_in, csign_ff, csign_in, cnz_ff, cnz_in;
   logic [32:0]   c_ext, c_mag;
   logic [DW:0]   rem_sh;
   logic          q_bit;

   assign c_ext  = {dividend[tmo_pkg::DATA_W-1], dividend};
   assign c_mag  = dividend[tmo_pkg::DATA_W-1] ? (~c_ext + 33'd1) : c_ext;
   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign q_bit  = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      num_in   = num_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      csign_in = csign_ff;
      cnz_in   = cnz_ff;
      if (start) begin
         num_in   = NW'(c_mag) << FRAC_BITS;
         den_in   = divisor[DW-1] ? (~divisor + DW'(1)) : divisor;
         rem_in   = '0;
         quo_in   = '0;
         cnt_in   = CW'(NW);
         busy_in  = 1'b1;
         neg_in   = dividend[tmo_pkg::DATA_W-1] ^ divisor[DW-1];
         zero_in  = (divisor == '0);
         csign_in = dividend[tmo_pkg::DATA_W-1];
         cnz_in   = (dividend != '0);
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in = q_bit ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         quo_in = {quo_ff[NW-2:0], q_bit};
         num_in = {num_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      csign_ff <= csign_in;
      cnz_ff   <= cnz_in;
   end

   // sign and saturation
   always_comb begin
      if (zero_ff) begin
         quotient = csign_ff ? 32'h8000_0000 : (cnz_ff ? 32'h7FFF_FFFF : 32'h0);
      end else if (neg_ff) begin
         quotient = (quo_ff > NW'(33'h0_8000_0000)) ? 32'h8000_0000
                                                    : (~quo_ff[31:0] + 32'd1);
      end else begin
         quotient = (quo_ff > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_ff[31:0];
      end
   end

   assign done = done_ff;

endmodule

### rtl/core/tmo_sqrt.sv
// Integer square root, one root bit (two radicand bits) per cycle
module tmo_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] rad_ff, rad_in;
   logic [31:0] root_ff, root_in;
   logic [33:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [35:0] rem_sh, trial;

   assign rem_sh = {rem_ff, rad_ff[63:62]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         rad_in = {rad_ff[61:0], 2'b00};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/core/tmo_cordic.sv
// Vectoring CORDIC, one micro-rotation per cycle; angle 2^31 = pi
module tmo_cordic #(
   parameter int CORDIC_STEPS = tmo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [32:0]                 x_in,
   input  logic [32:0]                 y_in,
   output logic                        done,
   output logic [tmo_pkg::ANGLE_W-1:0] angle
);
   localparam int W  = tmo_pkg::CORDIC_W;
   localparam int AW = tmo_pkg::ANGLE_W;
   localparam int CW = $clog2(CORDIC_STEPS + 1);

   logic signed [W-1:0]  x_ff, x_in_n, y_ff, y_in_n, xs, ys, dx, dy;
   logic signed [AW-1:0] z_ff, z_in;
   logic [CW-1:0]        i_ff, i_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [AW-1:0]        step_angle;

   assign xs = $signed({{3{x_in[32]}}, x_in, 16'b0});
   assign ys = $signed({{3{y_in[32]}}, y_in, 16'b0});
   assign dx = y_ff >>> i_ff[4:0];
   assign dy = x_ff >>> i_ff[4:0];
   assign step_angle = AW'(tmo_pkg::ATAN_TAB[i_ff[4:0]]);

   always_comb begin
      x_in_n  = x_ff;
      y_in_n  = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // pre-rotate left half plane by a quarter turn
         x_in_n  = xs;
         y_in_n  = ys;
         z_in    = '0;
         if (xs < 0) begin
            if (ys >= 0) begin
               x_in_n = ys;
               y_in_n = -xs;
               z_in   = $signed(tmo_pkg::QUARTER_TURN);
            end else begin
               x_in_n = -ys;
               y_in_n = xs;
               z_in   = -$signed(tmo_pkg::QUARTER_TURN);
            end
         end
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // y zero stays where it is
         if (y_ff > 0) begin
            x_in_n = x_ff + dx;
            y_in_n = y_ff - dy;
            z_in   = z_ff + $signed(step_angle);
         end else if (y_ff < 0) begin
            x_in_n = x_ff - dx;
            y_in_n = y_ff + dy;
            z_in   = z_ff - $signed(step_angle);
         end
         i_in = i_ff + CW'(1);
         if (i_ff == CW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in_n;
      y_ff <= y_in_n;
      z_ff <= z_in;
      i_ff <= i_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule
